// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk and quiet during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HKRH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HKRH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/hkrh_pkg.sv -----
// ---------------------------------------------------------------------------
// hkrh_pkg
// Types and fixed constants shared by the key report hold manager
// ---------------------------------------------------------------------------
package hkrh_pkg;

  localparam int OP_W        = 2;
  localparam int CODE_W      = 8;
  localparam int HOLD_W      = 7;
  localparam int MOD_COUNT   = 8;
  localparam int MOD_IDX_W   = 3;
  localparam int REPORT_KEYS = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // request opcodes as they arrive on the input channel
  typedef enum logic [OP_W-1:0] {
    OP_ADD_KEY = 2'd0,
    OP_ADD_MOD = 2'd1,
    OP_TICK    = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  // command kinds after classification
  typedef enum logic [1:0] {
    CMD_NOP  = 2'd0,
    CMD_KEY  = 2'd1,
    CMD_MOD  = 2'd2,
    CMD_TICK = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CODE_W-1:0] code;
    logic [HOLD_W-1:0] hold;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic                              report_sent;
    logic [CODE_W-1:0]                 modifier_bits;
    logic [REPORT_KEYS-1:0][CODE_W-1:0] keys;
    logic                              all_released;
  } result_t;

endpackage

// ----- src/hkrh_if.sv -----
// ---------------------------------------------------------------------------
// hkrh_if
// Valid/ready channels for requests in and report results out
// ---------------------------------------------------------------------------
interface hkrh_in_if;
  logic                        valid;
  logic                        ready;
  logic [hkrh_pkg::OP_W-1:0]   opcode;
  logic [hkrh_pkg::CODE_W-1:0] code;
  logic [hkrh_pkg::HOLD_W-1:0] hold_ticks;

  modport source (output valid, output opcode, output code, output hold_ticks, input ready);
  modport sink   (input valid, input opcode, input code, input hold_ticks, output ready);
endinterface

interface hkrh_out_if;
  logic                        valid;
  logic                        ready;
  logic                        report_sent;
  logic [hkrh_pkg::CODE_W-1:0] modifier_bits;
  logic [hkrh_pkg::CODE_W-1:0] key_first;
  logic [hkrh_pkg::CODE_W-1:0] key_second;
  logic [hkrh_pkg::CODE_W-1:0] key_third;
  logic [hkrh_pkg::CODE_W-1:0] key_fourth;
  logic [hkrh_pkg::CODE_W-1:0] key_fifth;
  logic [hkrh_pkg::CODE_W-1:0] key_sixth;
  logic                        all_released;

  modport source (output valid, output report_sent, output modifier_bits,
                  output key_first, output key_second, output key_third,
                  output key_fourth, output key_fifth, output key_sixth,
                  output all_released, input ready);
  modport sink   (input valid, input report_sent, input modifier_bits,
                  input key_first, input key_second, input key_third,
                  input key_fourth, input key_fifth, input key_sixth,
                  input all_released, output ready);
endinterface

// ----- src/hkrh_front.sv -----
// ---------------------------------------------------------------------------
// hkrh_front
// Request decode and two-entry command queue feeding the executor
// ---------------------------------------------------------------------------
module hkrh_front (
  input  logic                clk,
  input  logic                rst_n,
  hkrh_in_if.sink             in_chan,
  output hkrh_pkg::cmd_head_t cmd_head,
  input  logic                cmd_pop
);

  hkrh_pkg::cmd_t                   q_mem_r [hkrh_pkg::QUEUE_DEPTH];
  logic [hkrh_pkg::QPTR_W-1:0]      q_wr_r;
  logic [hkrh_pkg::QPTR_W-1:0]      q_rd_r;
  logic [hkrh_pkg::QCNT_W-1:0]      q_count_r;
  hkrh_pkg::cmd_t                   cmd_in;
  logic                             push;

  // classify: drop zero key codes and out-of-range modifier indexes here
  always_comb begin
    cmd_in.code = in_chan.code;
    cmd_in.hold = in_chan.hold_ticks;
    case (hkrh_pkg::opcode_t'(in_chan.opcode))
      hkrh_pkg::OP_ADD_KEY:
        cmd_in.kind = (in_chan.code != '0) ? hkrh_pkg::CMD_KEY : hkrh_pkg::CMD_NOP;
      hkrh_pkg::OP_ADD_MOD:
        cmd_in.kind = (in_chan.code[hkrh_pkg::CODE_W-1:hkrh_pkg::MOD_IDX_W] == '0) ?
                      hkrh_pkg::CMD_MOD : hkrh_pkg::CMD_NOP;
      hkrh_pkg::OP_TICK: cmd_in.kind = hkrh_pkg::CMD_TICK;
      default:           cmd_in.kind = hkrh_pkg::CMD_NOP;
    endcase
  end

  assign in_chan.ready = (q_count_r != hkrh_pkg::QCNT_W'(hkrh_pkg::QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;

  // queue head towards the executor
  assign cmd_head.valid = (q_count_r != '0);
  assign cmd_head.cmd   = q_mem_r[q_rd_r];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r    <= '0;
      q_rd_r    <= '0;
      q_count_r <= '0;
    end else begin
      if (push) begin
        q_wr_r <= q_wr_r + 1'b1;
      end
      if (cmd_pop) begin
        q_rd_r <= q_rd_r + 1'b1;
      end
      if (push && !cmd_pop) begin
        q_count_r <= q_count_r + 1'b1;
      end else if (!push && cmd_pop) begin
        q_count_r <= q_count_r - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wr_r] <= cmd_in;
    end
  end

endmodule

// ----- src/hkrh_back.sv -----
// ---------------------------------------------------------------------------
// hkrh_back
// Command executor: report state, slot search, tick walk and result register
// ---------------------------------------------------------------------------
module hkrh_back #(
  parameter int KEY_SLOTS  = 6,
  parameter int TIMER_BITS = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hkrh_pkg::cmd_head_t cmd_head,
  output logic                cmd_pop,
  hkrh_out_if.source          out_chan
);

  localparam int IDX_W      = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int HOLD_EXT_W = (TIMER_BITS > hkrh_pkg::HOLD_W) ? TIMER_BITS : hkrh_pkg::HOLD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [hkrh_pkg::CODE_W-1:0]         key_slot_r  [KEY_SLOTS];
  logic [TIMER_BITS-1:0]               key_timer_r [KEY_SLOTS];
  logic [hkrh_pkg::MOD_COUNT-1:0]      mod_state_r;
  logic [TIMER_BITS-1:0]               mod_timer_r [hkrh_pkg::MOD_COUNT];
  logic [hkrh_pkg::CODE_W-1:0]         last_mod_r;
  logic [hkrh_pkg::REPORT_KEYS-1:0][hkrh_pkg::CODE_W-1:0] last_keys_r;
  logic [1:0]                          phase_r;
  logic                                idle_r;
  logic [hkrh_pkg::CODE_W-1:0]         code_r;
  logic [TIMER_BITS-1:0]               hold_r;
  logic [IDX_W-1:0]                    idx_r;
  logic [IDX_W-1:0]                    wp_r;
  logic                                zero_acc_r;
  hkrh_pkg::result_t                   res_r;
  logic                                out_valid_r;
  hkrh_pkg::result_t                   out_data_r;

  logic [HOLD_EXT_W-1:0]               hold_ext;
  logic [HOLD_EXT_W-1:0]               hold_max_ext;
  logic [TIMER_BITS-1:0]               hold_clamped;
  logic [hkrh_pkg::REPORT_KEYS-1:0][hkrh_pkg::CODE_W-1:0] rep_keys;
  logic                                rep_changed;
  logic [TIMER_BITS-1:0]               mod_tdec [hkrh_pkg::MOD_COUNT];
  logic [hkrh_pkg::MOD_COUNT-1:0]      mod_live;
  logic [TIMER_BITS-1:0]               cur_timer;
  logic [TIMER_BITS-1:0]               cur_tdec;
  logic                                cur_live;
  logic [hkrh_pkg::CODE_W-1:0]         cur_slot;
  logic                                search_hit;
  logic                                is_last;
  logic                                out_free;
  hkrh_pkg::result_t                   res_start;

  // saturate the requested hold to the timer range
  assign hold_ext     = HOLD_EXT_W'(cmd_head.cmd.hold);
  assign hold_max_ext = HOLD_EXT_W'({TIMER_BITS{1'b1}});
  assign hold_clamped = (hold_ext > hold_max_ext) ? TIMER_BITS'(hold_max_ext)
                                                  : TIMER_BITS'(hold_ext);

  // current report: slots past the configured count read as zero
  for (genvar g = 0; g < hkrh_pkg::REPORT_KEYS; g++) begin : g_rep
    if (g < KEY_SLOTS) begin : g_live
      assign rep_keys[g] = key_slot_r[g];
    end else begin : g_zero
      assign rep_keys[g] = '0;
    end
  end

  assign rep_changed = (mod_state_r != last_mod_r) || (rep_keys != last_keys_r);

  // modifier countdowns, all eight in parallel
  always_comb begin
    for (int m = 0; m < hkrh_pkg::MOD_COUNT; m++) begin
      mod_tdec[m] = (mod_timer_r[m] != '0) ? mod_timer_r[m] - 1'b1 : mod_timer_r[m];
      mod_live[m] = (mod_tdec[m] != '0);
    end
  end

  // slot under the walk pointer
  assign cur_timer  = key_timer_r[idx_r];
  assign cur_slot   = key_slot_r[idx_r];
  assign cur_tdec   = (cur_timer != '0) ? cur_timer - 1'b1 : cur_timer;
  assign cur_live   = (cur_tdec != '0);
  assign search_hit = (cur_slot == code_r) || (cur_timer == '0);
  assign is_last    = (idx_r == LAST_IDX);

  assign out_free = !out_valid_r || out_chan.ready;
  assign cmd_pop  = (state_r == ST_IDLE) && cmd_head.valid;

  // result as known when the command is taken
  always_comb begin
    res_start              = '0;
    res_start.all_released = idle_r;
    if ((cmd_head.cmd.kind == hkrh_pkg::CMD_TICK) && rep_changed) begin
      res_start.report_sent   = 1'b1;
      res_start.modifier_bits = mod_state_r;
      res_start.keys          = rep_keys;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_head.valid) begin
          case (cmd_head.cmd.kind)
            hkrh_pkg::CMD_KEY:  state_nxt = ST_SEARCH;
            hkrh_pkg::CMD_TICK: state_nxt = ST_WALK;
            default:            state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (search_hit || is_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_WALK: begin
        if (is_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // report state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mod_state_r <= '0;
      last_mod_r  <= '0;
      last_keys_r <= '0;
      phase_r     <= '0;
      idle_r      <= 1'b0;
      idx_r       <= '0;
      wp_r        <= '0;
      zero_acc_r  <= 1'b0;
      for (int k = 0; k < KEY_SLOTS; k++) begin
        key_slot_r[k]  <= '0;
        key_timer_r[k] <= '0;
      end
      for (int m = 0; m < hkrh_pkg::MOD_COUNT; m++) begin
        mod_timer_r[m] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // output register fills from the done state and empties on acceptance
      out_valid_r <= ((state_r == ST_DONE) && out_free) || (out_valid_r && !out_chan.ready);
      case (state_r)
        ST_IDLE: begin
          if (cmd_pop) begin
            idx_r <= '0;
            wp_r  <= '0;
            case (cmd_head.cmd.kind)
              hkrh_pkg::CMD_MOD: begin
                if (hold_clamped != '0) begin
                  mod_state_r[cmd_head.cmd.code[hkrh_pkg::MOD_IDX_W-1:0]] <= 1'b1;
                end
                mod_timer_r[cmd_head.cmd.code[hkrh_pkg::MOD_IDX_W-1:0]] <= hold_clamped;
              end
              hkrh_pkg::CMD_TICK: begin
                // three-tick repeat rule against the last-sent copy
                if (rep_changed) begin
                  if (phase_r == 2'd1) begin
                    phase_r <= 2'd0;
                  end else if (phase_r == 2'd2) begin
                    phase_r <= 2'd1;
                  end else begin
                    last_mod_r  <= mod_state_r;
                    last_keys_r <= rep_keys;
                    phase_r     <= 2'd2;
                  end
                end
                for (int m = 0; m < hkrh_pkg::MOD_COUNT; m++) begin
                  mod_timer_r[m] <= mod_tdec[m];
                end
                mod_state_r <= mod_live;
                zero_acc_r  <= ~|mod_live;
              end
              default: ;
            endcase
          end
        end
        ST_SEARCH: begin
          if (search_hit) begin
            if (hold_r != '0) begin
              key_slot_r[idx_r] <= code_r;
            end
            key_timer_r[idx_r] <= hold_r;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_WALK: begin
          // count down, drop expired slot, move live slot to the packing point
          if (!cur_live || (wp_r != idx_r)) begin
            key_slot_r[idx_r]  <= '0;
            key_timer_r[idx_r] <= '0;
          end
          if (cur_live) begin
            key_slot_r[wp_r]  <= cur_slot;
            key_timer_r[wp_r] <= cur_tdec;
            wp_r              <= wp_r + 1'b1;
          end
          zero_acc_r <= zero_acc_r & !cur_live;
          if (is_last) begin
            idle_r <= zero_acc_r & !cur_live;
          end
          idx_r <= idx_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // command operands, pending result and output register
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          code_r <= cmd_head.cmd.code;
          hold_r <= hold_clamped;
          res_r  <= res_start;
        end
      end
      ST_WALK: begin
        if (is_last) begin
          res_r.all_released <= zero_acc_r & !cur_live;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.report_sent   = out_data_r.report_sent;
  assign out_chan.modifier_bits = out_data_r.modifier_bits;
  assign out_chan.key_first     = out_data_r.keys[0];
  assign out_chan.key_second    = out_data_r.keys[1];
  assign out_chan.key_third     = out_data_r.keys[2];
  assign out_chan.key_fourth    = out_data_r.keys[3];
  assign out_chan.key_fifth     = out_data_r.keys[4];
  assign out_chan.key_sixth     = out_data_r.keys[5];
  assign out_chan.all_released  = out_data_r.all_released;

endmodule

// ----- src/hid_key_report_hold_manager.sv -----
// ---------------------------------------------------------------------------
// hid_key_report_hold_manager
// Keyboard report with per-key and per-modifier hold countdowns
// ---------------------------------------------------------------------------
// Every request gives exactly one result. Requests are decoded into a
// two-entry command queue, so the input keeps accepting until both entries
// are full, also while the executor works or a finished result waits in the
// output register. The executor takes one command at a time: add-modifier,
// ignored and unused requests go straight to the done state; add-key walks
// the key slots one per cycle until a match, a free slot or the last slot;
// a report tick walks all slots, counting down, dropping and packing them.
// The report is always six key bytes wide; slots past KEY_SLOTS read as zero.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hid_key_report_hold_manager #(
  parameter int KEY_SLOTS  = 6,
  parameter int TIMER_BITS = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  hkrh_in_if.sink    in_chan,
  hkrh_out_if.source out_chan
);

  hkrh_pkg::cmd_head_t cmd_head;
  logic                cmd_pop;

  // decode and queue
  hkrh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cmd_head (cmd_head),
    .cmd_pop  (cmd_pop)
  );

  // executor
  hkrh_back #(
    .KEY_SLOTS  (KEY_SLOTS),
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_head (cmd_head),
    .cmd_pop  (cmd_pop),
    .out_chan (out_chan)
  );

  // checks
  `HKRH_ASSERT_IMPL(a_pop_needs_cmd, cmd_pop, cmd_head.valid, "executor popped an empty queue")
  `HKRH_ASSERT_NEXT(a_head_holds, cmd_head.valid && !cmd_pop, cmd_head.valid && $stable(cmd_head.cmd), "queue head changed without a pop")
  `HKRH_ASSERT_IMPL(a_quiet_result, out_chan.valid && !out_chan.report_sent, out_chan.modifier_bits == 8'd0 && out_chan.key_first == 8'd0 && out_chan.key_sixth == 8'd0, "unsent result carries report bytes")

endmodule
